@@ rtl/svpd_pkg.sv @@
// Shared types, constants and tables for the space vector PWM duty pipeline.
package svpd_pkg;

   localparam int DUTY_BITS_DEF  = 16;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int CORDIC_STEPS   = 30;

   localparam logic [31:0]        ANGLE_EPS       = 32'd6836;
   localparam logic [16:0]        SQRT3_Q16       = 17'd113512;
   localparam logic signed [32:0] CORDIC_X0       = 33'sd652032874;
   localparam logic [15:0]        DUTY_LIMIT_RST  = 16'd10498;
   localparam logic [9:0]         SAT_VOLTAGE_RST = 10'd64;

   typedef enum logic {
      CSR_DUTY_LIMIT  = 1'b0,
      CSR_SAT_VOLTAGE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] u_alpha;
      logic signed [15:0] u_beta;
      logic [14:0]        voltage_magnitude;
      logic [14:0]        dc_bus_voltage;
      logic signed [15:0] current_u;
      logic signed [15:0] current_v;
      logic signed [15:0] current_w;
   } req_type;

   typedef struct packed {
      logic [15:0] duty_u;
      logic [15:0] duty_v;
      logic [15:0] duty_w;
      logic [2:0]  sector;
   } rsp_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input int unsigned i);
      logic [31:0] r;
      case (i)
         0:  r = 32'd536870912;
         1:  r = 32'd316933406;
         2:  r = 32'd167458907;
         3:  r = 32'd85004756;
         4:  r = 32'd42667331;
         5:  r = 32'd21354465;
         6:  r = 32'd10679838;
         7:  r = 32'd5340245;
         8:  r = 32'd2670163;
         9:  r = 32'd1335087;
         10: r = 32'd667544;
         11: r = 32'd333772;
         12: r = 32'd166886;
         13: r = 32'd83443;
         14: r = 32'd41722;
         15: r = 32'd20861;
         16: r = 32'd10430;
         17: r = 32'd5215;
         18: r = 32'd2608;
         19: r = 32'd1304;
         20: r = 32'd652;
         21: r = 32'd326;
         22: r = 32'd163;
         23: r = 32'd81;
         24: r = 32'd41;
         25: r = 32'd20;
         26: r = 32'd10;
         27: r = 32'd5;
         28: r = 32'd3;
         29: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   // floor(k * 2^32 / 6): sector boundaries in 2^-32 turn
   function automatic logic [32:0] sector_bound(input logic [2:0] k);
      logic [32:0] r;
      case (k)
         3'd0: r = 33'd0;
         3'd1: r = 33'd715827882;
         3'd2: r = 33'd1431655765;
         3'd3: r = 33'd2147483648;
         3'd4: r = 33'd2863311530;
         3'd5: r = 33'd3579139413;
         3'd6: r = 33'd4294967296;
         default: r = 33'd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/space_vector_pwm_duty.sv @@
// Space vector PWM duty pipeline: angle, sector, scaled times and per-phase compare values.
//
// Input: a beat is taken at every clock edge where start is high; busy stays low, so a
// new vector may be offered every cycle. Each beat carries the voltage vector, its
// magnitude, the bus voltage and the three phase currents.
// Output: rsp_valid is high for one cycle with the three compare values and the sector,
// once the beat has passed every register stage listed below. One result per input beat,
// in order.
// Throughput is one beat per cycle: a capture stage, every CORDIC iteration (30 for the
// angle, 30 for the two sines), the angle stage and the sine clamp stage each have their
// own register stage, followed by two multiplier stages and three combine stages; the
// restoring dividers (one quotient bit a stage) run alongside.
// Configuration: csr_we writes duty_limit (index 0) or sat_voltage (index 1) at once;
// write only while no beat is in flight.
// Reset: synchronous, clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall, so there is no back-pressure anywhere in the pipeline.
module space_vector_pwm_duty
   import svpd_pkg::*;
#(
   parameter int DUTY_BITS  = DUTY_BITS_DEF,
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata
);

   localparam int LIM_W  = (DUTY_BITS < 16) ? DUTY_BITS : 16;
   localparam int NUM_W  = 30 + LIM_W;
   localparam int L_W    = DUTY_BITS + 18;
   localparam int T_W    = L_W + 2;
   localparam int S_W    = L_W + 4;
   localparam int VX_W   = 39;
   localparam int SX_W   = 33;
   localparam int SZ_W   = 34;
   localparam int VEC_N  = CORDIC_STEPS;
   localparam int SIN_N  = CORDIC_STEPS;
   localparam int ST_ANG = VEC_N + 1;
   localparam int ST_CLP = ST_ANG + SIN_N + 1;
   localparam int ST_M1  = ST_CLP + 1;
   localparam int ST_M2  = ST_M1 + 1;
   localparam int ST_H   = ST_M2 + 1;
   localparam int ST_PH  = ST_H + 1;
   localparam int ST_OUT = ST_PH + 1;
   localparam int DIV_END = NUM_W + 1;
   localparam int LEN_D  = ST_CLP - DIV_END;
   localparam int OFF_D  = ST_PH - DIV_END;
   localparam int SEC_N  = ST_PH - ST_ANG;
   localparam logic [L_W-1:0] LMAX = {L_W{1'b1}};

   function automatic logic [L_W-1:0] sat_quot(input logic [NUM_W-1:0] q,
                                                input logic nz, input logic dzero);
      logic [L_W-1:0] r;
      if (!nz) begin
         r = '0;
      end else if (dzero || (|q[NUM_W-1:L_W])) begin
         r = LMAX;
      end else begin
         r = q[L_W-1:0];
      end
      return r;
   endfunction

   logic [15:0]      duty_limit_ff;
   logic [9:0]       sat_voltage_ff;
   logic [LIM_W-1:0] limit;
   logic [0:ST_OUT]  v_ff;

   assign busy  = 1'b0;
   assign limit = duty_limit_ff[LIM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_limit_ff  <= DUTY_LIMIT_RST;
         sat_voltage_ff <= SAT_VOLTAGE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DUTY_LIMIT:  duty_limit_ff  <= csr_wdata;
            CSR_SAT_VOLTAGE: sat_voltage_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {start, v_ff[0:ST_OUT-1]};
      end
   end

   // ---------------- stage 0: capture, half-turn pre-rotation, dividends
   logic signed [VX_W-1:0] ax, by;
   logic [NUM_W-1:0]       num_len, num_off;

   assign ax      = VX_W'($signed({req_data.u_alpha, 20'd0}));
   assign by      = VX_W'($signed({req_data.u_beta, 20'd0}));
   assign num_len = (NUM_W'(req_data.voltage_magnitude) * NUM_W'(limit)) << 15;
   assign num_off = (NUM_W'(sat_voltage_ff) * NUM_W'(limit)) << 15;

   logic signed [VX_W-1:0] vx_ff [0:VEC_N];
   logic signed [VX_W-1:0] vy_ff [0:VEC_N];
   logic [31:0]            vz_ff [0:VEC_N];
   logic                   vzero_ff [0:VEC_N];
   logic [14:0]            dden_ff [0:NUM_W];
   logic [14:0]            lrem_ff [0:NUM_W];
   logic [14:0]            orem_ff [0:NUM_W];
   logic [NUM_W-1:0]       lnq_ff [0:NUM_W];
   logic [NUM_W-1:0]       onq_ff [0:NUM_W];
   logic                   lnz_ff [0:NUM_W];
   logic                   onz_ff [0:NUM_W];
   logic [2:0]             cpos_ff [0:ST_PH];
   logic [2:0]             cneg_ff [0:ST_PH];

   always_ff @(posedge clock) begin
      if (req_data.u_alpha < 0) begin
         vx_ff[0] <= -ax;
         vy_ff[0] <= -by;
         vz_ff[0] <= 32'h8000_0000;
      end else begin
         vx_ff[0] <= ax;
         vy_ff[0] <= by;
         vz_ff[0] <= 32'd0;
      end
      vzero_ff[0] <= (req_data.u_alpha == 0) && (req_data.u_beta == 0);
      dden_ff[0]  <= req_data.dc_bus_voltage;
      lrem_ff[0]  <= '0;
      orem_ff[0]  <= '0;
      lnq_ff[0]   <= num_len;
      onq_ff[0]   <= num_off;
      lnz_ff[0]   <= (num_len != '0);
      onz_ff[0]   <= (num_off != '0);
      cpos_ff[0]  <= {req_data.current_w > 0, req_data.current_v > 0, req_data.current_u > 0};
      cneg_ff[0]  <= {req_data.current_w < 0, req_data.current_v < 0, req_data.current_u < 0};
   end

   for (genvar k = 1; k <= ST_PH; k++) begin : g_cur
      always_ff @(posedge clock) begin
         cpos_ff[k] <= cpos_ff[k-1];
         cneg_ff[k] <= cneg_ff[k-1];
      end
   end

   // ---------------- vectoring CORDIC, one iteration a stage
   for (genvar i = 0; i < VEC_N; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (vy_ff[i] > 0) begin
            vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
            vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
            vz_ff[i+1] <= vz_ff[i] + atan_turn(i);
         end else begin
            vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
            vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
            vz_ff[i+1] <= vz_ff[i] - atan_turn(i);
         end
         vzero_ff[i+1] <= vzero_ff[i];
      end
   end

   // ---------------- restoring dividers, one quotient bit a stage
   for (genvar j = 0; j < NUM_W; j++) begin : g_div
      logic [15:0] ltrial, otrial;
      assign ltrial = {lrem_ff[j], lnq_ff[j][NUM_W-1]};
      assign otrial = {orem_ff[j], onq_ff[j][NUM_W-1]};
      always_ff @(posedge clock) begin
         if (ltrial >= {1'b0, dden_ff[j]}) begin
            lrem_ff[j+1] <= 15'(ltrial - {1'b0, dden_ff[j]});
            lnq_ff[j+1]  <= {lnq_ff[j][NUM_W-2:0], 1'b1};
         end else begin
            lrem_ff[j+1] <= ltrial[14:0];
            lnq_ff[j+1]  <= {lnq_ff[j][NUM_W-2:0], 1'b0};
         end
         if (otrial >= {1'b0, dden_ff[j]}) begin
            orem_ff[j+1] <= 15'(otrial - {1'b0, dden_ff[j]});
            onq_ff[j+1]  <= {onq_ff[j][NUM_W-2:0], 1'b1};
         end else begin
            orem_ff[j+1] <= otrial[14:0];
            onq_ff[j+1]  <= {onq_ff[j][NUM_W-2:0], 1'b0};
         end
         dden_ff[j+1] <= dden_ff[j];
         lnz_ff[j+1]  <= lnz_ff[j];
         onz_ff[j+1]  <= onz_ff[j];
      end
   end

   logic [L_W-1:0] len_d_ff [0:LEN_D];
   logic [L_W-1:0] off_d_ff [0:OFF_D];

   // saturate the quotients, then hold them until the multiply and offset stages
   always_ff @(posedge clock) begin
      len_d_ff[0] <= sat_quot(lnq_ff[NUM_W], lnz_ff[NUM_W], dden_ff[NUM_W] == '0);
      off_d_ff[0] <= sat_quot(onq_ff[NUM_W], onz_ff[NUM_W], dden_ff[NUM_W] == '0);
   end

   for (genvar k = 1; k <= LEN_D; k++) begin : g_len_d
      always_ff @(posedge clock) len_d_ff[k] <= len_d_ff[k-1];
   end

   for (genvar k = 1; k <= OFF_D; k++) begin : g_off_d
      always_ff @(posedge clock) off_d_ff[k] <= off_d_ff[k-1];
   end

   // ---------------- angle, sector and sine arguments
   logic [31:0]           z_eps;
   logic [ANGLE_BITS-1:0] ang;
   logic [ANGLE_BITS+2:0] ang6;
   logic [2:0]            sec_m1;
   logic [31:0]           a32;
   logic [32:0]           bound_lo, bound_hi;
   logic signed [SZ_W-1:0] th1, th2;

   assign z_eps    = (vzero_ff[VEC_N] ? 32'd0 : vz_ff[VEC_N]) + ANGLE_EPS;
   assign ang      = z_eps[31 -: ANGLE_BITS];
   assign ang6     = (ANGLE_BITS+3)'(ang) * (ANGLE_BITS+3)'(6);
   assign sec_m1   = ang6[ANGLE_BITS+2:ANGLE_BITS];
   assign a32      = {ang, {(32-ANGLE_BITS){1'b0}}};
   assign bound_lo = sector_bound(sec_m1);
   assign bound_hi = sector_bound(sec_m1 + 3'd1);
   assign th1      = $signed(SZ_W'(bound_hi) - SZ_W'(a32));
   assign th2      = $signed(SZ_W'(a32) - SZ_W'(bound_lo));

   logic signed [SX_W-1:0] sx1_ff [0:SIN_N];
   logic signed [SX_W-1:0] sy1_ff [0:SIN_N];
   logic signed [SZ_W-1:0] sz1_ff [0:SIN_N];
   logic signed [SX_W-1:0] sx2_ff [0:SIN_N];
   logic signed [SX_W-1:0] sy2_ff [0:SIN_N];
   logic signed [SZ_W-1:0] sz2_ff [0:SIN_N];
   logic [2:0]             sec_ff [0:SEC_N];

   always_ff @(posedge clock) begin
      sx1_ff[0] <= CORDIC_X0;
      sy1_ff[0] <= '0;
      sz1_ff[0] <= th1;
      sx2_ff[0] <= CORDIC_X0;
      sy2_ff[0] <= '0;
      sz2_ff[0] <= th2;
      sec_ff[0] <= sec_m1 + 3'd1;
   end

   for (genvar k = 1; k <= SEC_N; k++) begin : g_sec
      always_ff @(posedge clock) sec_ff[k] <= sec_ff[k-1];
   end

   // ---------------- two rotation CORDICs side by side
   for (genvar i = 0; i < SIN_N; i++) begin : g_sin
      logic signed [SZ_W-1:0] at;
      assign at = $signed(SZ_W'(atan_turn(i)));
      always_ff @(posedge clock) begin
         if (sz1_ff[i] >= 0) begin
            sx1_ff[i+1] <= sx1_ff[i] - (sy1_ff[i] >>> i);
            sy1_ff[i+1] <= sy1_ff[i] + (sx1_ff[i] >>> i);
            sz1_ff[i+1] <= sz1_ff[i] - at;
         end else begin
            sx1_ff[i+1] <= sx1_ff[i] + (sy1_ff[i] >>> i);
            sy1_ff[i+1] <= sy1_ff[i] - (sx1_ff[i] >>> i);
            sz1_ff[i+1] <= sz1_ff[i] + at;
         end
         if (sz2_ff[i] >= 0) begin
            sx2_ff[i+1] <= sx2_ff[i] - (sy2_ff[i] >>> i);
            sy2_ff[i+1] <= sy2_ff[i] + (sx2_ff[i] >>> i);
            sz2_ff[i+1] <= sz2_ff[i] - at;
         end else begin
            sx2_ff[i+1] <= sx2_ff[i] + (sy2_ff[i] >>> i);
            sy2_ff[i+1] <= sy2_ff[i] - (sx2_ff[i] >>> i);
            sz2_ff[i+1] <= sz2_ff[i] + at;
         end
      end
   end

   // ---------------- sine scaling and clamp to 0..1.0 in Q16
   logic signed [SX_W-1:0] s_sh1, s_sh2;
   logic [16:0]            s1_ff, s2_ff;

   assign s_sh1 = sy1_ff[SIN_N] >>> 14;
   assign s_sh2 = sy2_ff[SIN_N] >>> 14;

   always_ff @(posedge clock) begin
      if (s_sh1 < 0)          s1_ff <= '0;
      else if (s_sh1 > 65536) s1_ff <= 17'd65536;
      else                    s1_ff <= s_sh1[16:0];
      if (s_sh2 < 0)          s2_ff <= '0;
      else if (s_sh2 > 65536) s2_ff <= 17'd65536;
      else                    s2_ff <= s_sh2[16:0];
   end

   // ---------------- length times sine, then times sqrt(3)
   logic [L_W+16:0] prod1, prod2;
   logic [L_W:0]    p1_ff, p2_ff;
   logic [L_W+17:0] tprod1, tprod2;
   logic [T_W-1:0]  t1_ff, t2_ff;

   assign prod1  = (L_W+17)'(len_d_ff[LEN_D]) * (L_W+17)'(s1_ff);
   assign prod2  = (L_W+17)'(len_d_ff[LEN_D]) * (L_W+17)'(s2_ff);
   assign tprod1 = (L_W+18)'(p1_ff) * (L_W+18)'(SQRT3_Q16);
   assign tprod2 = (L_W+18)'(p2_ff) * (L_W+18)'(SQRT3_Q16);

   always_ff @(posedge clock) begin
      p1_ff <= prod1[L_W+16:16];
      p2_ff <= prod2[L_W+16:16];
      t1_ff <= tprod1[L_W+17:16];
      t2_ff <= tprod2[L_W+17:16];
   end

   // ---------------- half of the idle time, and the active times alone and summed
   logic signed [S_W-1:0] full_s, t0_s;
   logic signed [S_W-1:0] h_ff, ta_ff, tb_ff, tab_ff;

   assign full_s = $signed(S_W'({limit, 16'd0}));
   assign t0_s   = $signed(S_W'(full_s) - S_W'(t1_ff) - S_W'(t2_ff));

   always_ff @(posedge clock) begin
      h_ff   <= t0_s >>> 1;
      ta_ff  <= $signed(S_W'(t1_ff));
      tb_ff  <= $signed(S_W'(t2_ff));
      tab_ff <= $signed(S_W'(t1_ff) + S_W'(t2_ff));
   end

   // ---------------- centred phase values by sector
   logic signed [S_W-1:0] pu_ff, pv_ff, pw_ff;

   always_ff @(posedge clock) begin
      case (sec_ff[SEC_N-1])
         3'd1: begin
            pu_ff <= tab_ff + h_ff; pv_ff <= tb_ff + h_ff;  pw_ff <= h_ff;
         end
         3'd2: begin
            pu_ff <= ta_ff + h_ff;  pv_ff <= tab_ff + h_ff; pw_ff <= h_ff;
         end
         3'd3: begin
            pu_ff <= h_ff;          pv_ff <= tab_ff + h_ff; pw_ff <= tb_ff + h_ff;
         end
         3'd4: begin
            pu_ff <= h_ff;          pv_ff <= ta_ff + h_ff;  pw_ff <= tab_ff + h_ff;
         end
         3'd5: begin
            pu_ff <= tb_ff + h_ff;  pv_ff <= h_ff;          pw_ff <= tab_ff + h_ff;
         end
         default: begin
            pu_ff <= tab_ff + h_ff; pv_ff <= h_ff;          pw_ff <= ta_ff + h_ff;
         end
      endcase
   end

   // ---------------- dead-time offset by current sign, clamp, truncate
   logic signed [S_W-1:0] off_s;
   logic signed [S_W-1:0] qu, qv, qw;
   logic [LIM_W-1:0]      du, dv, dw;
   rsp_type               rsp_ff;

   assign off_s = $signed(S_W'(off_d_ff[OFF_D]));
   assign qu = cpos_ff[ST_PH][0] ? pu_ff + off_s : (cneg_ff[ST_PH][0] ? pu_ff - off_s : pu_ff);
   assign qv = cpos_ff[ST_PH][1] ? pv_ff + off_s : (cneg_ff[ST_PH][1] ? pv_ff - off_s : pv_ff);
   assign qw = cpos_ff[ST_PH][2] ? pw_ff + off_s : (cneg_ff[ST_PH][2] ? pw_ff - off_s : pw_ff);
   assign du = (qu > full_s) ? limit : ((qu < 0) ? '0 : qu[LIM_W+15:16]);
   assign dv = (qv > full_s) ? limit : ((qv < 0) ? '0 : qv[LIM_W+15:16]);
   assign dw = (qw > full_s) ? limit : ((qw < 0) ? '0 : qw[LIM_W+15:16]);

   always_ff @(posedge clock) begin
      rsp_ff.duty_u <= 16'(du);
      rsp_ff.duty_v <= 16'(dv);
      rsp_ff.duty_w <= 16'(dw);
      rsp_ff.sector <= sec_ff[SEC_N];
   end

   assign rsp_valid = v_ff[ST_OUT];
   assign rsp_data  = rsp_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##(ST_OUT+1) rsp_valid)
      else $error("result beat missing after pipeline latency");

   a_sector_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sector >= 3'd1) && (rsp_data.sector <= 3'd6))
      else $error("sector out of range");

   a_sine_args : assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_ANG] |-> (sz1_ff[0] >= 0) && (sz2_ff[0] >= 0))
      else $error("negative sine argument from sector split");

endmodule
